>>> design/base64_codec_core_macros.svh
// Assertion macros used by the base64 codec job queue and back stage.
`ifndef BASE64_CODEC_CORE_MACROS_SVH
`define BASE64_CODEC_CORE_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define B64_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition never occurs outside reset.
`define B64_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> design/b64_pkg.sv
// Types, constants and character mapping functions for the base64 codec.
`default_nettype none

package b64_pkg;

  localparam int unsigned NumRes = 4;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCw    = $clog2(QDepth + 1);

  localparam logic [7:0] PadChar = 8'd61;

  typedef enum logic {
    MODE_DECODE = 1'b0,
    MODE_ENCODE = 1'b1
  } mode_e;

  localparam mode_e ModeReset = MODE_ENCODE;

  typedef struct packed {
    logic [NumRes-1:0][7:0] bytes;
    logic [2:0]             cnt;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.value = '0;
    if (c >= 8'd65 && c <= 8'd90) begin
      s.value = 6'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      s.value = 6'(c - 8'd71);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      s.value = 6'(c + 8'd4);
    end else if (c == 8'd43) begin
      s.value = 6'd62;
    end else if (c == 8'd47) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/b64_front.sv
// Front stage: accepts items, gathers groups and builds result jobs.
`default_nettype none

module b64_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          mode_we_i,
  input  wire logic          mode_i,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_stream_i,
  output b64_pkg::job_t      job_o,
  output logic               job_push_o
);

  b64_pkg::mode_e   mode_q, mode_d;
  logic [23:0]      gb_q, gb_d;
  logic [2:0]       cnt_q, cnt_d;
  b64_pkg::sextet_t sx;
  logic [23:0]      gb_n;
  logic [2:0]       cnt_n;
  logic [23:0]      w;
  logic             emit;

  assign sx = b64_pkg::sextet_of(data_byte_i);

  always_comb begin
    mode_d     = mode_q;
    gb_d       = gb_q;
    cnt_d      = cnt_q;
    gb_n       = gb_q;
    cnt_n      = cnt_q;
    w          = '0;
    emit       = 1'b0;
    job_o      = '0;
    job_push_o = 1'b0;
    unique case (mode_q)
      b64_pkg::MODE_ENCODE: begin
        gb_n  = {gb_q[15:0], data_byte_i};
        cnt_n = cnt_q + 3'd1;
        emit  = (cnt_n >= 3'd3) || end_of_stream_i;
        unique case (cnt_n)
          3'd1:    w = {gb_n[7:0], 16'h0000};
          3'd2:    w = {gb_n[15:0], 8'h00};
          default: w = gb_n;
        endcase
        job_o.bytes[0] = b64_pkg::enc_char(w[23:18]);
        job_o.bytes[1] = b64_pkg::enc_char(w[17:12]);
        job_o.bytes[2] = (cnt_n > 3'd1) ? b64_pkg::enc_char(w[11:6]) : b64_pkg::PadChar;
        job_o.bytes[3] = (cnt_n > 3'd2) ? b64_pkg::enc_char(w[5:0]) : b64_pkg::PadChar;
        job_o.cnt      = 3'd4;
      end
      b64_pkg::MODE_DECODE: begin
        if (sx.valid) begin
          gb_n  = {gb_q[17:0], sx.value};
          cnt_n = cnt_q + 3'd1;
        end
        emit = (cnt_n >= 3'd4) || (end_of_stream_i && (cnt_n != 3'd0));
        unique case (cnt_n)
          3'd1:    w = {gb_n[5:0], 18'h00000};
          3'd2:    w = {gb_n[11:0], 12'h000};
          3'd3:    w = {gb_n[17:0], 6'h00};
          default: w = gb_n;
        endcase
        job_o.bytes[0] = w[23:16];
        job_o.bytes[1] = w[15:8];
        job_o.bytes[2] = w[7:0];
        job_o.bytes[3] = 8'h00;
        job_o.cnt      = cnt_n - 3'd1;
      end
      default: ;
    endcase

    if (accept_i) begin
      job_push_o = emit && (job_o.cnt != 3'd0);
      gb_d       = emit ? 24'h000000 : gb_n;
      cnt_d      = emit ? 3'd0 : cnt_n;
    end

    if (mode_we_i) begin
      mode_d = b64_pkg::mode_e'(mode_i);
      gb_d   = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= b64_pkg::ModeReset;
      gb_q   <= '0;
      cnt_q  <= '0;
    end else begin
      mode_q <= mode_d;
      gb_q   <= gb_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> design/b64_fifo.sv
// Job queue between the front and back stages.
`default_nettype none

`include "base64_codec_core_macros.svh"

module b64_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire b64_pkg::job_t data_i,
  output logic               full_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output b64_pkg::job_t      head_o
);

  b64_pkg::job_t                 mem_q [b64_pkg::QDepth];
  logic [b64_pkg::QAw-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [b64_pkg::QCw-1:0]       cnt_q, cnt_d;

  localparam logic [b64_pkg::QAw-1:0] LastIdx = b64_pkg::QAw'(b64_pkg::QDepth - 1);
  localparam logic [b64_pkg::QCw-1:0] Depth   = b64_pkg::QCw'(b64_pkg::QDepth);

  assign full_o  = (cnt_q == Depth);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `B64_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "job queue overflow")
  `B64_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "job queue underflow")

endmodule

`default_nettype wire

>>> design/b64_back.sv
// Back stage: serializes job bytes onto the result port.
`default_nettype none

`include "base64_codec_core_macros.svh"

module b64_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire b64_pkg::job_t job_i,
  input  wire logic          job_empty_i,
  output logic               job_pop_o,
  output logic               empty_o,
  input  wire logic          pop_i,
  output logic [7:0]         out_byte_o,
  output logic               last_o
);

  logic [b64_pkg::NumRes-1:0][7:0] bytes_q, bytes_d;
  logic [2:0]                      rem_q, rem_d;

  assign empty_o    = (rem_q == 3'd0);
  assign out_byte_o = bytes_q[0];
  assign last_o     = (rem_q == 3'd1);

  always_comb begin
    bytes_d   = bytes_q;
    rem_d     = rem_q;
    job_pop_o = 1'b0;
    if (pop_i && !empty_o) begin
      bytes_d = {8'h00, bytes_q[b64_pkg::NumRes-1:1]};
      rem_d   = rem_q - 3'd1;
    end
    if (!job_empty_i && (empty_o || (pop_i && last_o))) begin
      job_pop_o = 1'b1;
      bytes_d   = job_i.bytes;
      rem_d     = job_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  `B64_ASSERT(a_hold_out, clk_i, rst_ni, (!empty_o && !pop_i) |=> $stable(out_byte_o),
    "result changed while stalled")
  `B64_ASSERT(a_refill, clk_i, rst_ni, (pop_i && last_o && !job_empty_i) |=> !empty_o,
    "missed back-to-back job")

endmodule

`default_nettype wire

>>> design/base64_codec_core.sv
// Top level of the streaming base64 encoder and decoder.
//
// Channel   Direction  Transfer when       Fields
// input     in         push && !full       data_byte_i, end_of_stream_i
// result    out        pop && !empty       out_byte_o, last_o
// mode      in         mode_we_i           mode_i
//
// Decode takes one item per cycle when the queue has room; encode is limited by
// the one-byte-per-cycle result register, as three items give four bytes.
// An item's first result is held in a queue entry, then in the result register.
// Reset selects encode mode and clears the group, queue and result register.
// A two-entry job queue lets input and result sides stall independently.
`default_nettype none

module base64_codec_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        mode_we_i,
  input  wire logic        mode_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_stream_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             last_o
);

  b64_pkg::job_t job_in, job_head;
  logic          job_push, job_pop, job_empty;

  b64_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_we_i       (mode_we_i),
    .mode_i          (mode_i),
    .accept_i        (push && !full),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .job_o           (job_in),
    .job_push_o      (job_push)
  );

  b64_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .empty_o (job_empty),
    .pop_i   (job_pop),
    .head_o  (job_head)
  );

  b64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_head),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
